/* rtl/pcm_pkg.sv */
`timescale 1ns / 1ps

package pcm_pkg;

  localparam int MaxPixels = 4096;
  localparam int MaxPlanes = 16;
  localparam int PosW = 12;
  localparam int SizeW = 13;
  localparam int PlaneW = 4;
  localparam int DistW = 18;
  localparam int SumW = 31;
  localparam int CountW = 13;
  localparam int ScaleW = 32;
  localparam int DividendW = CountW + 31;

  localparam logic [SumW-1:0] SumLimit = {SumW{1'b1}};
  localparam logic [31:0] ExpUnit = 32'd4294901760;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdEmit = 1'b1;

  localparam logic CfgFramePixels = 1'b0;
  localparam logic CfgOutputPlanes = 1'b1;

  // One emit request as it travels from the front part to the back part.
  typedef struct packed {
    logic                error;
    logic                valid;
    logic [DistW-1:0]    distance;
    logic [ScaleW-1:0]   scale;
    logic [PlaneW-1:0]   plane;
    logic [PosW-1:0]     pixel;
    logic                last;
  } pcm_job_t;

  typedef struct packed {
    logic               start;
    logic [DividendW-1:0] dividend;
    logic [SumW-1:0]    divisor;
  } pcm_div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ScaleW-1:0] quotient;
  } pcm_div_rsp_t;

endpackage

/* rtl/pcm_divider.sv */
`timescale 1ns / 1ps

module pcm_divider import pcm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  pcm_div_req_t req,
  output pcm_div_rsp_t rsp
);

  logic [DividendW-1:0] quot;
  logic [SumW:0]        rem;
  logic [SumW-1:0]      divisor;
  logic [5:0]           count;
  logic                 busy;
  logic                 done;
  logic [SumW+1:0]      shifted;
  logic [SumW+1:0]      diff;

  // Restoring division, one quotient bit per cycle.
  assign shifted = {rem, quot[DividendW-1]};
  assign diff = shifted - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quot <= req.dividend;
        divisor <= req.divisor;
        rem <= '0;
        count <= 6'(DividendW);
      end else if (busy) begin
        if (!diff[SumW+1]) begin
          rem <= diff[SumW:0];
          quot <= {quot[DividendW-2:0], 1'b1};
        end else begin
          rem <= shifted[SumW:0];
          quot <= {quot[DividendW-2:0], 1'b0};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quotient = (quot[DividendW-1:ScaleW] != '0) ? {ScaleW{1'b1}} : quot[ScaleW-1:0];

endmodule

/* rtl/pcm_front.sv */
`timescale 1ns / 1ps

module pcm_front import pcm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              command,
  input  logic signed [15:0] warped_red,
  input  logic signed [15:0] warped_green,
  input  logic signed [15:0] warped_blue,
  input  logic signed [15:0] target_red,
  input  logic signed [15:0] target_green,
  input  logic signed [15:0] target_blue,
  input  logic [SizeW-1:0]  size,
  input  logic [4:0]        planes,
  input  pcm_div_rsp_t      div_rsp,
  output pcm_div_req_t      div_req,
  output logic              push,
  output pcm_job_t          push_job
);

  logic [DistW:0]     store [MaxPixels];
  logic [DistW:0]     rd_data;
  logic [SumW-1:0]    distance_sum;
  logic [CountW-1:0]  valid_count;
  logic [SizeW-1:0]   load_position;
  logic [PosW-1:0]    emit_position;
  logic [PlaneW-1:0]  emit_plane;
  logic [ScaleW-1:0]  scale_reciprocal;
  logic               image_loaded;
  logic               pend;
  pcm_job_t           pend_job;

  function automatic logic [16:0] absdiff(input logic signed [15:0] a,
                                          input logic signed [15:0] b);
    logic signed [16:0] d;
    d = 17'(a) - 17'(b);
    return d[16] ? 17'(-d) : d;
  endfunction

  logic [DistW-1:0]   pix_dist;
  logic               pix_valid;
  logic [SumW-1:0]    base_sum;
  logic [CountW-1:0]  base_count;
  logic [SizeW-1:0]   base_pos;
  logic [SumW:0]      sum_add;
  logic [SumW-1:0]    sum_next;
  logic [CountW-1:0]  count_next;
  logic [SizeW-1:0]   pos_next;
  logic               end_plane;
  logic               end_image;

  always_comb begin
    pix_dist = DistW'(absdiff(warped_red, target_red))
             + DistW'(absdiff(warped_green, target_green))
             + DistW'(absdiff(warped_blue, target_blue));
    pix_valid = (warped_red | warped_green | warped_blue) != 16'd0;
    base_sum = image_loaded ? '0 : distance_sum;
    base_count = image_loaded ? '0 : valid_count;
    base_pos = image_loaded ? '0 : load_position;
    sum_add = {1'b0, base_sum} + (SumW+1)'(pix_dist);
    sum_next = base_sum;
    count_next = base_count;
    if (pix_valid) begin
      sum_next = sum_add[SumW] ? SumLimit : sum_add[SumW-1:0];
      count_next = base_count + CountW'(1);
    end
    pos_next = base_pos + SizeW'(1);
    end_plane = ({1'b0, emit_position} + SizeW'(1)) >= size;
    end_image = end_plane && (({1'b0, emit_plane} + 5'd1) >= planes);
  end

  always_ff @(posedge clk) begin
    if (accept && command == CmdLoad) begin
      store[base_pos[PosW-1:0]] <= {pix_valid, pix_dist};
    end
    if (accept && command == CmdEmit) begin
      rd_data <= store[emit_position];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_sum <= '0;
      valid_count <= '0;
      load_position <= '0;
      emit_position <= '0;
      emit_plane <= '0;
      scale_reciprocal <= '0;
      image_loaded <= 1'b0;
      pend <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      pend <= 1'b0;
      div_req.start <= 1'b0;
      if (div_rsp.done) begin
        scale_reciprocal <= div_rsp.quotient;
      end
      if (accept && command == CmdLoad) begin
        distance_sum <= sum_next;
        valid_count <= count_next;
        load_position <= pos_next;
        image_loaded <= 1'b0;
        scale_reciprocal <= '0;
        emit_position <= '0;
        emit_plane <= '0;
        if (pos_next >= size) begin
          image_loaded <= 1'b1;
          if (sum_next != '0) begin
            div_req.start <= 1'b1;
            div_req.dividend <= {count_next, 31'd0};
            div_req.divisor <= sum_next;
          end
        end
      end else if (accept) begin
        pend <= 1'b1;
        pend_job.error <= !image_loaded;
        pend_job.valid <= 1'b0;
        pend_job.distance <= '0;
        // The quotient lands in the same cycle an emit may be taken, so it is passed on.
        pend_job.scale <= div_rsp.done ? div_rsp.quotient : scale_reciprocal;
        pend_job.plane <= image_loaded ? emit_plane : '0;
        pend_job.pixel <= image_loaded ? emit_position : '0;
        pend_job.last <= image_loaded && end_image;
        if (image_loaded) begin
          if (end_image) begin
            distance_sum <= '0;
            valid_count <= '0;
            load_position <= '0;
            emit_position <= '0;
            emit_plane <= '0;
            scale_reciprocal <= '0;
            image_loaded <= 1'b0;
          end else if (end_plane) begin
            emit_position <= '0;
            emit_plane <= emit_plane + PlaneW'(1);
          end else begin
            emit_position <= emit_position + PosW'(1);
          end
        end
      end
    end
  end

  always_comb begin
    push = pend;
    push_job = pend_job;
    push_job.valid = rd_data[DistW] && !pend_job.error;
    push_job.distance = rd_data[DistW-1:0];
  end

endmodule

/* rtl/pcm_queue.sv */
`timescale 1ns / 1ps

module pcm_queue import pcm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  pcm_job_t push_job,
  input  logic     pop,
  output pcm_job_t head,
  output logic     empty,
  output logic [1:0] count
);

  pcm_job_t slots [2];
  logic     wr_ptr;
  logic     rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign head = slots[rd_ptr];
  assign empty = (count == 2'd0);

endmodule

/* rtl/pcm_back.sv */
`timescale 1ns / 1ps

module pcm_back import pcm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  pcm_job_t         head,
  output logic             pop,
  output logic             result_valid,
  output logic [15:0]      confidence,
  output logic [PlaneW-1:0] plane_number,
  output logic [PosW-1:0]  pixel_number,
  output logic             last_of_image,
  output logic             request_error
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SXMul = 3'd1;
  localparam logic [2:0] SXChk = 3'd2;
  localparam logic [2:0] SAMul = 3'd3;
  localparam logic [2:0] SAUpd = 3'd4;
  localparam logic [2:0] SEMul = 3'd5;
  localparam logic [2:0] SEUpd = 3'd6;
  localparam logic [2:0] SDone = 3'd7;

  logic [2:0]  state;
  pcm_job_t    job;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;
  logic [63:0] prod_rnd;
  logic [19:0] xbits;
  logic [4:0]  bit_idx;
  logic [31:0] acc;
  logic        acc_one;
  logic [31:0] e;
  logic [32:0] acc_rnd;

  assign prod_rnd = prod + 64'h8000_0000;
  assign acc_rnd = {1'b0, acc} + 33'h8000;
  assign pop = (state == SIdle) && !empty;

  always_ff @(posedge clk) begin
    prod <= 64'(op_a) * 64'(op_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        SIdle: begin
          if (!empty) begin
            job <= head;
            op_a <= 32'(head.distance);
            op_b <= head.scale;
            state <= head.error ? SDone : SXMul;
          end
        end
        SXMul: state <= SXChk;
        SXChk: begin
          acc_one <= 1'b1;
          e <= ExpUnit;
          bit_idx <= '0;
          xbits <= prod[35:16];
          if (!job.valid || prod[49:36] != '0) begin
            acc_one <= 1'b0;
            acc <= '0;
            state <= SDone;
          end else begin
            op_a <= acc;
            op_b <= ExpUnit;
            state <= SAMul;
          end
        end
        SAMul: state <= SAUpd;
        SAUpd: begin
          if (xbits[bit_idx]) begin
            acc <= acc_one ? e : prod_rnd[63:32];
            acc_one <= 1'b0;
          end
          op_a <= e;
          op_b <= e;
          state <= SEMul;
        end
        SEMul: state <= SEUpd;
        SEUpd: begin
          e <= prod_rnd[63:32];
          op_a <= acc;
          op_b <= prod_rnd[63:32];
          if (bit_idx == 5'd19) begin
            state <= SDone;
          end else begin
            bit_idx <= bit_idx + 5'd1;
            state <= SAMul;
          end
        end
        SDone: begin
          result_valid <= 1'b1;
          request_error <= job.error;
          plane_number <= job.plane;
          pixel_number <= job.pixel;
          last_of_image <= job.last;
          if (job.error) begin
            confidence <= '0;
          end else if (acc_one || acc_rnd[32]) begin
            confidence <= 16'hFFFF;
          end else begin
            confidence <= acc_rnd[31:16];
          end
          state <= SIdle;
        end
        default: state <= SIdle;
      endcase
    end
  end

endmodule

/* rtl/photometric_confidence_map_core.sv */
`timescale 1ns / 1ps
// Load beats are taken back to back; the beat that completes an image with a nonzero sum
// holds busy while the restoring divider forms the reciprocal scale, one bit a cycle. The
// back part takes no new emit beat until done with the last: twenty square-and-multiply
// steps of exp on one 32x32 multiplier, each a multiply of the result and a squaring. Two
// emit beats queue ahead of the back part; the receiver cannot stall results. Synchronous
// active-high reset clears all control state and restores register defaults.

module photometric_confidence_map_core import pcm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic signed [15:0] warped_red,
  input  logic signed [15:0] warped_green,
  input  logic signed [15:0] warped_blue,
  input  logic signed [15:0] target_red,
  input  logic signed [15:0] target_green,
  input  logic signed [15:0] target_blue,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [12:0]        cfg_data,
  output logic               result_valid,
  output logic [15:0]        confidence,
  output logic [3:0]         plane_number,
  output logic [11:0]        pixel_number,
  output logic               last_of_image,
  output logic               request_error
);

  // Configuration registers, taken as written and clamped where they are used.
  logic [12:0] frame_pixels;
  logic [4:0]  output_planes;
  logic [SizeW-1:0] size;
  logic [4:0]  planes;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pixels <= 13'(MaxPixels);
      output_planes <= 5'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        CfgFramePixels: frame_pixels <= cfg_data;
        CfgOutputPlanes: output_planes <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    size = frame_pixels;
    if (frame_pixels == '0) size = SizeW'(1);
    else if (frame_pixels > SizeW'(MaxPixels)) size = SizeW'(MaxPixels);
    planes = output_planes;
    if (output_planes == '0) planes = 5'd1;
    else if (output_planes > 5'(MaxPlanes)) planes = 5'(MaxPlanes);
  end

  pcm_div_req_t div_req;
  pcm_div_rsp_t div_rsp;
  logic         accept;
  logic         push;
  pcm_job_t     push_job;
  logic         pop;
  pcm_job_t     head;
  logic         empty;
  logic [1:0]   count;

  // A beat is taken only if the queue has room for it and for one emit still being read
  // out of the distance store.
  assign busy = div_rsp.busy || div_req.start || ({1'b0, count} + 3'(push) >= 3'd2);
  assign accept = start && !busy;

  pcm_front u_front (
    .clk, .rst, .accept, .command,
    .warped_red, .warped_green, .warped_blue,
    .target_red, .target_green, .target_blue,
    .size, .planes, .div_rsp, .div_req, .push, .push_job
  );

  pcm_divider u_divider (
    .clk, .rst, .req(div_req), .rsp(div_rsp)
  );

  pcm_queue u_queue (
    .clk, .rst, .push, .push_job, .pop, .head, .empty, .count
  );

  pcm_back u_back (
    .clk, .rst, .empty, .head, .pop, .result_valid, .confidence,
    .plane_number, .pixel_number, .last_of_image, .request_error
  );

endmodule
